### rtl/drive_safety_supervisor_defines.svh
// assertion macros shared by the supervisor rtl
`ifndef DRIVE_SAFETY_SUPERVISOR_DEFINES_SVH
`define DRIVE_SAFETY_SUPERVISOR_DEFINES_SVH

// same-cycle implication, clocked on clk and quiet during rst
`define DSS_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, clocked on clk and quiet during rst
`define DSS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/dss_pkg.sv
package dss_pkg;

  // request kinds
  typedef enum logic [2:0] {
    KIND_TICK        = 3'd0,
    KIND_HEARTBEAT   = 3'd1,
    KIND_COMMAND     = 3'd2,
    KIND_ESTOP       = 3'd3,
    KIND_ESTOP_CLEAR = 3'd4
  } kind_t;

  // status flag positions
  localparam int unsigned FLAG_ESTOP = 0;
  localparam int unsigned FLAG_HEART = 1;
  localparam int unsigned FLAG_CMD   = 2;
  localparam int unsigned FLAG_LOW   = 3;
  localparam int unsigned FLAG_CRIT  = 4;
  localparam int unsigned FLAG_FAULT = 5;
  localparam int unsigned FLAG_TEMP  = 6;
  localparam int unsigned FLAG_CURR  = 7;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_BATT_CRIT  = 3'd0,
    REG_BATT_WARN  = 3'd1,
    REG_TEMP_LIMIT = 3'd2,
    REG_CURR_LIMIT = 3'd3,
    REG_HB_TIMEOUT = 3'd4,
    REG_CMD_TIMEOUT = 3'd5
  } reg_index_t;

  localparam int unsigned PADDR_W = 5;

  // register reset values
  localparam logic [15:0]        BATT_CRIT_RESET   = 16'd11000;
  localparam logic [15:0]        BATT_WARN_RESET   = 16'd12000;
  localparam logic [7:0]         TEMP_LIMIT_RESET  = 8'd55;
  localparam logic signed [15:0] CURR_LIMIT_RESET  = 16'sd2500;
  localparam logic [31:0]        HB_TIMEOUT_RESET  = 32'd500;
  localparam logic [31:0]        CMD_TIMEOUT_RESET = 32'd250;

endpackage

### rtl/dss_item_if.sv
interface dss_item_if;
  import dss_pkg::*;

  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [31:0]        time_ms;
  logic [15:0]        battery_mv;
  logic [7:0]         temp_left_front;
  logic [7:0]         temp_right_front;
  logic [7:0]         temp_left_rear;
  logic [7:0]         temp_right_rear;
  logic signed [15:0] amps_left_front;
  logic signed [15:0] amps_right_front;
  logic signed [15:0] amps_left_rear;
  logic signed [15:0] amps_right_rear;
  logic               fault_in;

  modport source (
    output valid, kind, time_ms, battery_mv,
           temp_left_front, temp_right_front, temp_left_rear, temp_right_rear,
           amps_left_front, amps_right_front, amps_left_rear, amps_right_rear,
           fault_in,
    input  ready
  );

  modport sink (
    input  valid, kind, time_ms, battery_mv,
           temp_left_front, temp_right_front, temp_left_rear, temp_right_rear,
           amps_left_front, amps_right_front, amps_left_rear, amps_right_rear,
           fault_in,
    output ready
  );

endinterface

### rtl/dss_result_if.sv
interface dss_result_if;

  logic       valid;
  logic       ready;
  logic [7:0] error_flags;
  logic       operation_allowed;
  logic       motor_enable;
  logic       motor_stop;
  logic       clear_accepted;

  modport source (
    output valid, error_flags, operation_allowed, motor_enable, motor_stop,
           clear_accepted,
    input  ready
  );

  modport sink (
    input  valid, error_flags, operation_allowed, motor_enable, motor_stop,
           clear_accepted,
    output ready
  );

endinterface

### rtl/drive_safety_supervisor.sv
// Drive safety supervisor.
// Requests arrive on the item channel (valid/ready): a tick with battery,
// fault, temperature and current samples, a heartbeat, a command, an
// emergency-stop trigger or an emergency-stop clear. Each request gives one
// response on the result channel: eight error flags, operation_allowed, the
// motor enable level, a stop command and clear_accepted.
// From acceptance to a valid response, the request sits in the input register
// while the flag logic runs against the status, timestamps and enable level,
// and the response register is loaded, with the new state, when it advances.
// Throughput is one request per cycle while the receiver takes responses; the
// input register and the response register each hand on as soon as the next
// stage frees up. If the receiver stalls, the response is held, the input
// register fills and ready then drops until the response is taken.
// Reset (rst, synchronous) clears all flags, unarms both timers, sets the
// motor enable level and restores the threshold registers to their defaults.
// Thresholds are written over the APB port; the user must write them only
// while no request is in flight, and the block itself does not enforce it.
`include "drive_safety_supervisor_defines.svh"

module drive_safety_supervisor
  import dss_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  dss_item_if.sink            item,
  dss_result_if.source        result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // configuration registers
  logic [15:0]        battery_critical_mv;
  logic [15:0]        battery_warning_mv;
  logic [7:0]         temp_limit_c;
  logic signed [15:0] current_limit_ma;
  logic [31:0]        hb_limit_ms;
  logic [31:0]        cmd_limit_ms;

  reg_index_t reg_index;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign reg_index = reg_index_t'(paddr[PADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite;

  // apb register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      battery_critical_mv <= BATT_CRIT_RESET;
      battery_warning_mv  <= BATT_WARN_RESET;
      temp_limit_c        <= TEMP_LIMIT_RESET;
      current_limit_ma    <= CURR_LIMIT_RESET;
      hb_limit_ms         <= HB_TIMEOUT_RESET;
      cmd_limit_ms        <= CMD_TIMEOUT_RESET;
    end else if (cfg_write) begin
      case (reg_index)
        REG_BATT_CRIT:   battery_critical_mv <= pwdata[15:0];
        REG_BATT_WARN:   battery_warning_mv  <= pwdata[15:0];
        REG_TEMP_LIMIT:  temp_limit_c        <= pwdata[7:0];
        REG_CURR_LIMIT:  current_limit_ma    <= pwdata[15:0];
        REG_HB_TIMEOUT:  hb_limit_ms         <= pwdata;
        REG_CMD_TIMEOUT: cmd_limit_ms        <= pwdata;
        default: ;
      endcase
    end
  end

  // apb readback
  always_comb begin
    case (reg_index)
      REG_BATT_CRIT:   prdata = {16'd0, battery_critical_mv};
      REG_BATT_WARN:   prdata = {16'd0, battery_warning_mv};
      REG_TEMP_LIMIT:  prdata = {24'd0, temp_limit_c};
      REG_CURR_LIMIT:  prdata = {{16{current_limit_ma[15]}}, current_limit_ma};
      REG_HB_TIMEOUT:  prdata = hb_limit_ms;
      REG_CMD_TIMEOUT: prdata = cmd_limit_ms;
      default:         prdata = 32'd0;
    endcase
  end

  // input register
  logic               in_valid;
  kind_t              in_kind;
  logic [31:0]        in_time_ms;
  logic [15:0]        in_battery_mv;
  logic [7:0]         in_temp [4];
  logic signed [15:0] in_amps [4];
  logic               in_fault;
  logic               advance;

  assign advance    = in_valid && (!result.valid || result.ready);
  assign item.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_kind       <= kind_t'(item.kind);
      in_time_ms    <= item.time_ms;
      in_battery_mv <= item.battery_mv;
      in_temp[0]    <= item.temp_left_front;
      in_temp[1]    <= item.temp_right_front;
      in_temp[2]    <= item.temp_left_rear;
      in_temp[3]    <= item.temp_right_rear;
      in_amps[0]    <= item.amps_left_front;
      in_amps[1]    <= item.amps_right_front;
      in_amps[2]    <= item.amps_left_rear;
      in_amps[3]    <= item.amps_right_rear;
      in_fault      <= item.fault_in;
    end
  end

  // supervisor state
  logic [7:0]  status_bits, status_bits_next;
  logic [31:0] last_heartbeat, last_heartbeat_next;
  logic [31:0] last_command, last_command_next;
  logic        enable_level, enable_level_next;
  logic        stop_next;
  logic        accepted_next;

  logic        hot;
  logic        over;
  logic [31:0] hb_age;
  logic [31:0] cmd_age;
  logic        cmd_timed_out;

  // limit checks on the four motors
  always_comb begin
    hot  = 1'b0;
    over = 1'b0;
    for (int m = 0; m < 4; m++) begin
      if (in_temp[m] > temp_limit_c) hot = 1'b1;
      if (in_amps[m] > current_limit_ma) over = 1'b1;
    end
  end

  assign hb_age        = in_time_ms - last_heartbeat;
  assign cmd_age       = in_time_ms - last_command;
  assign cmd_timed_out = cmd_age > cmd_limit_ms;

  // per-request state update
  always_comb begin
    status_bits_next    = status_bits;
    last_heartbeat_next = last_heartbeat;
    last_command_next   = last_command;
    enable_level_next   = enable_level;
    stop_next           = 1'b0;
    accepted_next       = 1'b0;
    case (in_kind)
      KIND_TICK: begin
        status_bits_next[FLAG_CRIT]  = in_battery_mv < battery_critical_mv;
        status_bits_next[FLAG_LOW]   = in_battery_mv < battery_warning_mv;
        status_bits_next[FLAG_FAULT] = in_fault;
        status_bits_next[FLAG_TEMP]  = hot;
        status_bits_next[FLAG_CURR]  = over;
        // zero timestamp leaves a timer unarmed
        if (last_heartbeat != 32'd0) begin
          status_bits_next[FLAG_HEART] = hb_age > hb_limit_ms;
        end
        if (last_command != 32'd0) begin
          status_bits_next[FLAG_CMD] = cmd_timed_out;
          if (cmd_timed_out) stop_next = 1'b1;
        end
        if (status_bits_next[FLAG_ESTOP] || status_bits_next[FLAG_HEART] ||
            status_bits_next[FLAG_CRIT] || status_bits_next[FLAG_FAULT]) begin
          enable_level_next = 1'b0;
          stop_next         = 1'b1;
        end
      end
      KIND_HEARTBEAT: begin
        last_heartbeat_next          = in_time_ms;
        status_bits_next[FLAG_HEART] = 1'b0;
      end
      KIND_COMMAND: begin
        last_command_next          = in_time_ms;
        status_bits_next[FLAG_CMD] = 1'b0;
      end
      KIND_ESTOP: begin
        status_bits_next[FLAG_ESTOP] = 1'b1;
        enable_level_next            = 1'b0;
        stop_next                    = 1'b1;
      end
      KIND_ESTOP_CLEAR: begin
        // refused while battery critical or fault present
        if (!status_bits[FLAG_CRIT] && !status_bits[FLAG_FAULT]) begin
          status_bits_next[FLAG_ESTOP] = 1'b0;
          enable_level_next            = 1'b1;
          accepted_next                = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status_bits    <= '0;
      last_heartbeat <= '0;
      last_command   <= '0;
      enable_level   <= 1'b1;
    end else if (advance) begin
      status_bits    <= status_bits_next;
      last_heartbeat <= last_heartbeat_next;
      last_command   <= last_command_next;
      enable_level   <= enable_level_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else begin
      result.valid <= advance || (result.valid && !result.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.error_flags       <= status_bits_next;
      result.operation_allowed <= !(status_bits_next[FLAG_ESTOP] ||
                                    status_bits_next[FLAG_HEART] ||
                                    status_bits_next[FLAG_CRIT] ||
                                    status_bits_next[FLAG_FAULT]);
      result.motor_enable      <= enable_level_next;
      result.motor_stop        <= stop_next;
      result.clear_accepted    <= accepted_next;
    end
  end

  // checks
  `DSS_ASSERT_NEXT(a_estop_stops, advance && in_kind == KIND_ESTOP,
    result.valid && result.motor_stop && result.error_flags[FLAG_ESTOP] &&
    !result.motor_enable, "estop request did not stop the motors")
  `DSS_ASSERT_IMPL(a_disable_stops, $fell(enable_level),
    result.valid && result.motor_stop && !result.motor_enable,
    "motor enable dropped without a stop response")
  `DSS_ASSERT_IMPL(a_clear_ok, result.valid && result.clear_accepted,
    result.motor_enable && !result.error_flags[FLAG_ESTOP] &&
    !result.error_flags[FLAG_CRIT] && !result.error_flags[FLAG_FAULT],
    "clear accepted with blocking condition")
  `DSS_ASSERT_IMPL(a_allowed_flags, result.valid && result.operation_allowed,
    !result.error_flags[FLAG_ESTOP] && !result.error_flags[FLAG_HEART],
    "operation allowed with estop or heartbeat timeout")

endmodule

### bench/drive_safety_supervisor_tb.sv
module drive_safety_supervisor_tb
  import dss_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_AT     = 330;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned IDLE_PCT    = 27;

  // one request as offered on the item channel
  typedef struct {
    logic [2:0]         kind;
    logic [31:0]        time_ms;
    logic [15:0]        battery_mv;
    logic [7:0]         temp [4];
    logic signed [15:0] amps [4];
    logic               fault_in;
  } request_t;

  // one response as seen on the result channel
  typedef struct {
    logic [7:0] error_flags;
    logic       operation_allowed;
    logic       motor_enable;
    logic       motor_stop;
    logic       clear_accepted;
  } status_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  dss_item_if   item ();
  dss_result_if result ();

  drive_safety_supervisor dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item.sink),
    .result  (result.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // thresholds as the supervisor should hold them
  logic [15:0]        lim_batt_crit;
  logic [15:0]        lim_batt_warn;
  logic [7:0]         lim_temp;
  logic signed [15:0] lim_curr;
  logic [31:0]        lim_hb_timeout;
  logic [31:0]        lim_cmd_timeout;

  // supervisor state mirror
  logic [7:0]  sup_status = '0;
  logic [31:0] sup_hb_stamp = '0;
  logic [31:0] sup_cmd_stamp = '0;
  logic        sup_enable = 1'b1;

  request_t request_q [$];
  status_t  expected_status_q [$];
  request_t offered;
  status_t  observed;
  status_t  wanted;

  int unsigned accepted_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left;
  logic        hold_done;
  int unsigned error_count = 0;
  logic [31:0] sim_now;
  logic        steady;

  assign steady = (accepted_count >= 400) && (accepted_count < 450);

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic drive_allowed(input logic [7:0] s);
    return !(s[FLAG_ESTOP] || s[FLAG_HEART] || s[FLAG_CRIT] || s[FLAG_FAULT]);
  endfunction

  // next status of the supervisor for one request, updating the mirror
  function automatic status_t supervise_request(input request_t r);
    status_t     s;
    logic        hot;
    logic        over;
    logic [31:0] age;
    logic        late;
    s.motor_stop = 1'b0;
    s.clear_accepted = 1'b0;
    case (r.kind)
      KIND_TICK: begin
        hot = 1'b0;
        over = 1'b0;
        for (int i = 0; i < 4; i++) begin
          if (r.temp[i] > lim_temp) hot = 1'b1;
          if (r.amps[i] > lim_curr) over = 1'b1;
        end
        sup_status[FLAG_CRIT]  = r.battery_mv < lim_batt_crit;
        sup_status[FLAG_LOW]   = r.battery_mv < lim_batt_warn;
        sup_status[FLAG_FAULT] = r.fault_in;
        sup_status[FLAG_TEMP]  = hot;
        sup_status[FLAG_CURR]  = over;
        // a zero stamp means the timer is unarmed
        if (sup_hb_stamp != 32'd0) begin
          age = r.time_ms - sup_hb_stamp;
          sup_status[FLAG_HEART] = age > lim_hb_timeout;
        end
        if (sup_cmd_stamp != 32'd0) begin
          age = r.time_ms - sup_cmd_stamp;
          late = age > lim_cmd_timeout;
          sup_status[FLAG_CMD] = late;
          if (late) s.motor_stop = 1'b1;
        end
        if (!drive_allowed(sup_status)) begin
          sup_enable = 1'b0;
          s.motor_stop = 1'b1;
        end
      end
      KIND_HEARTBEAT: begin
        sup_hb_stamp = r.time_ms;
        sup_status[FLAG_HEART] = 1'b0;
      end
      KIND_COMMAND: begin
        sup_cmd_stamp = r.time_ms;
        sup_status[FLAG_CMD] = 1'b0;
      end
      KIND_ESTOP: begin
        sup_status[FLAG_ESTOP] = 1'b1;
        sup_enable = 1'b0;
        s.motor_stop = 1'b1;
      end
      KIND_ESTOP_CLEAR: begin
        if (!sup_status[FLAG_CRIT] && !sup_status[FLAG_FAULT]) begin
          sup_status[FLAG_ESTOP] = 1'b0;
          sup_enable = 1'b1;
          s.clear_accepted = 1'b1;
        end
      end
      default: ;
    endcase
    s.error_flags = sup_status;
    s.operation_allowed = drive_allowed(sup_status);
    s.motor_enable = sup_enable;
    return s;
  endfunction

  function automatic request_t make_tick(input logic [31:0] t, input logic [15:0] mv,
                                         input logic [7:0] tmp,
                                         input logic signed [15:0] amp,
                                         input logic flt);
    request_t r;
    r.kind = KIND_TICK;
    r.time_ms = t;
    r.battery_mv = mv;
    for (int i = 0; i < 4; i++) begin
      r.temp[i] = tmp;
      r.amps[i] = amp;
    end
    r.fault_in = flt;
    return r;
  endfunction

  function automatic request_t make_event(input logic [2:0] k, input logic [31:0] t);
    request_t r;
    r = make_tick(t, 16'd0, 8'd0, 16'sd0, 1'b0);
    r.kind = k;
    return r;
  endfunction

  // random request: mostly plausible sensor values around the thresholds
  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    int unsigned sel;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 3) == 0) sim_now = sim_now + $urandom_range(0, 1200);
    else sim_now = sim_now + $urandom_range(0, 150);
    r.kind = KIND_TICK;
    r.time_ms = sim_now;
    case ($urandom_range(0, 3))
      0: r.battery_mv = 16'($urandom_range(0, 65535));
      1: r.battery_mv = lim_batt_crit + 16'($urandom_range(0, 6)) - 16'd3;
      2: r.battery_mv = lim_batt_warn + 16'($urandom_range(0, 6)) - 16'd3;
      default: r.battery_mv = 16'($urandom_range(10000, 14000));
    endcase
    for (int i = 0; i < 4; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) r.temp[i] = 8'($urandom_range(0, int'(lim_temp)));
      else if (sel < 8) r.temp[i] = lim_temp + 8'($urandom_range(0, 2)) - 8'd1;
      else r.temp[i] = 8'($urandom_range(0, 255));
      sel = $urandom_range(0, 9);
      if (sel < 6) r.amps[i] = lim_curr - 16'($urandom_range(0, 3000));
      else if (sel < 8) r.amps[i] = lim_curr + 16'($urandom_range(0, 2)) - 16'sd1;
      else r.amps[i] = 16'($urandom_range(0, 65535));
    end
    r.fault_in = ($urandom_range(0, 9) == 0);
    if (pick < 50) r.kind = KIND_TICK;
    else if (pick < 65) r.kind = KIND_HEARTBEAT;
    else if (pick < 80) r.kind = KIND_COMMAND;
    else if (pick < 86) r.kind = KIND_ESTOP;
    else if (pick < 95) r.kind = KIND_ESTOP_CLEAR;
    else if (pick < 97) begin
      // undefined kinds
      r.kind = 3'(KIND_ESTOP_CLEAR) + 3'($urandom_range(1, 3));
    end else if (pick < 99) begin
      // stamp of zero leaves the timer unarmed
      r.kind = ($urandom_range(0, 1) == 0) ? KIND_HEARTBEAT : KIND_COMMAND;
      r.time_ms = 32'd0;
    end else begin
      r.kind = 3'($urandom_range(0, 2));
      r.time_ms = $urandom();
    end
    return r;
  endfunction

  // apb write: setup then access
  task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_thresholds(input logic [15:0] crit, input logic [15:0] warn,
                                  input logic [7:0] tmp, input logic signed [15:0] curr,
                                  input logic [31:0] hb, input logic [31:0] cmd);
    write_reg(REG_BATT_CRIT, {16'd0, crit});
    write_reg(REG_BATT_WARN, {16'd0, warn});
    write_reg(REG_TEMP_LIMIT, {24'd0, tmp});
    write_reg(REG_CURR_LIMIT, {16'd0, curr});
    write_reg(REG_HB_TIMEOUT, hb);
    write_reg(REG_CMD_TIMEOUT, cmd);
    lim_batt_crit   = crit;
    lim_batt_warn   = warn;
    lim_temp        = tmp;
    lim_curr        = curr;
    lim_hb_timeout  = hb;
    lim_cmd_timeout = cmd;
  endtask

  // wait until every request has gone through and every response came back
  task automatic wait_idle();
    @(negedge clk);
    while (request_q.size() != 0 || item.valid || expected_status_q.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_random(input int unsigned count);
    @(negedge clk);
    for (int unsigned i = 0; i < count; i++) request_q.push_back(random_request());
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      error_count++;
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else begin
      if (item.valid && item.ready) begin
        expected_status_q.push_back(supervise_request(offered));
        accepted_count <= accepted_count + 1;
      end
      if (!item.valid || item.ready) begin
        if (request_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          offered = request_q.pop_front();
          item.valid            <= 1'b1;
          item.kind             <= offered.kind;
          item.time_ms          <= offered.time_ms;
          item.battery_mv       <= offered.battery_mv;
          item.temp_left_front  <= offered.temp[0];
          item.temp_right_front <= offered.temp[1];
          item.temp_left_rear   <= offered.temp[2];
          item.temp_right_rear  <= offered.temp[3];
          item.amps_left_front  <= offered.amps[0];
          item.amps_right_front <= offered.amps[1];
          item.amps_left_rear   <= offered.amps[2];
          item.amps_right_rear  <= offered.amps[3];
          item.fault_in         <= offered.fault_in;
        end else begin
          item.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        observed.error_flags       = result.error_flags;
        observed.operation_allowed = result.operation_allowed;
        observed.motor_enable      = result.motor_enable;
        observed.motor_stop        = result.motor_stop;
        observed.clear_accepted    = result.clear_accepted;
        if (expected_status_q.size() == 0) begin
          $error("response with no request outstanding: flags %0h", observed.error_flags);
          error_count++;
        end else begin
          wanted = expected_status_q.pop_front();
          check_field("error_flags", 32'(wanted.error_flags), 32'(observed.error_flags));
          check_field("operation_allowed", 32'(wanted.operation_allowed),
                      32'(observed.operation_allowed));
          check_field("motor_enable", 32'(wanted.motor_enable),
                      32'(observed.motor_enable));
          check_field("motor_stop", 32'(wanted.motor_stop), 32'(observed.motor_stop));
          check_field("clear_accepted", 32'(wanted.clear_accepted),
                      32'(observed.clear_accepted));
        end
      end
      result.ready <= (hold_left == 0) && (steady || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // one long receiver hold-off so the block backs up into the input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_count == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // run time guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("drive_safety_supervisor_tb: errors");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    lim_batt_crit   = BATT_CRIT_RESET;
    lim_batt_warn   = BATT_WARN_RESET;
    lim_temp        = TEMP_LIMIT_RESET;
    lim_curr        = CURR_LIMIT_RESET;
    lim_hb_timeout  = HB_TIMEOUT_RESET;
    lim_cmd_timeout = CMD_TIMEOUT_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed requests at the reset thresholds
    @(negedge clk);
    request_q.push_back(make_tick(32'd100, 16'd12500, 8'd0, 16'sd0, 1'b0));
    request_q.push_back(make_event(KIND_HEARTBEAT, 32'd0));
    request_q.push_back(make_event(KIND_COMMAND, 32'd0));
    request_q.push_back(make_tick(32'd200, 16'd11500, 8'd55, 16'sd2500, 1'b0));
    request_q.push_back(make_tick(32'd300, 16'd10999, 8'd56, 16'sd2501, 1'b0));
    // clear refused while battery is critical
    request_q.push_back(make_event(KIND_ESTOP_CLEAR, 32'd0));
    request_q.push_back(make_tick(32'd400, 16'hFFFF, 8'hFF, -16'sd32768, 1'b1));
    // clear refused while a fault is present
    request_q.push_back(make_event(KIND_ESTOP_CLEAR, 32'd0));
    request_q.push_back(make_tick(32'd500, 16'd12000, 8'd0, 16'sd32767, 1'b0));
    request_q.push_back(make_event(KIND_ESTOP_CLEAR, 32'd0));
    // timers armed, then aged to just inside and just past the limits
    request_q.push_back(make_event(KIND_HEARTBEAT, 32'd1000));
    request_q.push_back(make_event(KIND_COMMAND, 32'd1000));
    request_q.push_back(make_tick(32'd1250, 16'd12500, 8'd20, 16'sd100, 1'b0));
    request_q.push_back(make_tick(32'd1251, 16'd12500, 8'd20, 16'sd100, 1'b0));
    request_q.push_back(make_tick(32'd1501, 16'd12500, 8'd20, 16'sd100, 1'b0));
    request_q.push_back(make_event(KIND_HEARTBEAT, 32'd1600));
    request_q.push_back(make_event(KIND_COMMAND, 32'd1600));
    request_q.push_back(make_event(KIND_ESTOP, 32'd0));
    request_q.push_back(make_tick(32'd1700, 16'd12500, 8'd20, 16'sd100, 1'b0));
    request_q.push_back(make_event(KIND_ESTOP_CLEAR, 32'd0));
    // time wrapping past zero, and a time behind the stamp
    request_q.push_back(make_event(KIND_HEARTBEAT, 32'hFFFF_FF00));
    request_q.push_back(make_tick(32'h0000_0010, 16'd12500, 8'd20, 16'sd100, 1'b0));
    request_q.push_back(make_tick(32'hFFFF_FE00, 16'd12500, 8'd20, 16'sd100, 1'b0));
    request_q.push_back(make_event(3'(KIND_ESTOP_CLEAR) + 3'd1, 32'd0));
    request_q.push_back(make_event(3'(KIND_ESTOP_CLEAR) + 3'd3, 32'hFFFF_FFFF));
    wait_idle();

    // random at reset thresholds
    sim_now = $urandom_range(1, 100000);
    load_random(120);
    wait_idle();

    // extremes: nothing critical, everything times out at once
    apply_thresholds(16'd0, 16'hFFFF, 8'hFF, 16'sh7FFF, 32'd0, 32'd0);
    sim_now = 32'hFFFF_F000;
    load_random(80);
    wait_idle();

    // extremes: critical at any battery value but the maximum, timers never expire
    apply_thresholds(16'hFFFF, 16'd0, 8'd0, -16'sd32768, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    sim_now = $urandom();
    load_random(80);
    wait_idle();

    // ordinary thresholds, with the hold-off and the steady stretch
    apply_thresholds(16'($urandom_range(9000, 12000)), 16'($urandom_range(11000, 14000)),
                     8'($urandom_range(30, 90)), 16'($urandom_range(1000, 4000)),
                     $urandom_range(100, 800), $urandom_range(50, 400));
    sim_now = $urandom();
    load_random(170);
    wait_idle();

    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("drive_safety_supervisor_tb: clean");
    end else begin
      $display("drive_safety_supervisor_tb: errors");
    end
    $finish;
  end

endmodule
